// ----- hw/rtl/plb_pkg.sv -----
// Shared types and constants for the padded label bounding box.
package plb_pkg;

  localparam int LabelW = 8;
  localparam int CoordW = 10;
  localparam int PadW   = 9;
  localparam int HiW    = CoordW + 1;
  localparam int OutW   = 10;
  localparam int NumRegs = 8;
  localparam int RegIdxW = 3;
  localparam int AddrW   = RegIdxW + 2;
  localparam int DataW   = 32;
  localparam int InTdataW  = 32;
  localparam int OutTdataW = 8 * OutW;

  localparam logic [LabelW-1:0] LabelOuterMin = 8'd1;
  localparam logic [LabelW-1:0] LabelInnerMin = 8'd2;
  localparam logic [LabelW-1:0] LabelMax      = 8'd4;

  typedef enum logic [RegIdxW-1:0] {
    REG_PAD_OUTER_LEFT   = 3'd0,
    REG_PAD_OUTER_RIGHT  = 3'd1,
    REG_PAD_OUTER_TOP    = 3'd2,
    REG_PAD_OUTER_BOTTOM = 3'd3,
    REG_PAD_INNER_LEFT   = 3'd4,
    REG_PAD_INNER_RIGHT  = 3'd5,
    REG_PAD_INNER_TOP    = 3'd6,
    REG_PAD_INNER_BOTTOM = 3'd7
  } reg_idx_e;

  typedef logic [NumRegs-1:0][PadW-1:0] pad_array_t;

  typedef struct packed {
    logic              outer_hit;
    logic              inner_hit;
    logic              emit;
    logic [CoordW-1:0] lo_x;
    logic              lo_x_ok;
    logic [CoordW-1:0] lo_y;
    logic              lo_y_ok;
    logic [HiW-1:0]    hi_x;
    logic              hi_x_ok;
    logic [HiW-1:0]    hi_y;
    logic              hi_y_ok;
  } item_t;

  typedef struct packed {
    logic [OutW-1:0] inner_y_max;
    logic [OutW-1:0] inner_y_min;
    logic [OutW-1:0] inner_x_max;
    logic [OutW-1:0] inner_x_min;
    logic [OutW-1:0] outer_y_max;
    logic [OutW-1:0] outer_y_min;
    logic [OutW-1:0] outer_x_max;
    logic [OutW-1:0] outer_x_min;
  } box_t;

endpackage

// ----- hw/rtl/plb_cfg.sv -----
// Padding register file behind the APB port.
module plb_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [plb_pkg::AddrW-1:0]   paddr,
  input  logic [plb_pkg::DataW-1:0]   pwdata,
  output logic [plb_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output plb_pkg::pad_array_t         pads_o
);

  plb_pkg::pad_array_t                pads_q;
  logic [plb_pkg::RegIdxW-1:0]        idx;

  assign idx    = paddr[plb_pkg::AddrW-1:2];
  assign pready = 1'b1;
  assign prdata = {{(plb_pkg::DataW - plb_pkg::PadW){1'b0}}, pads_q[idx]};
  assign pads_o = pads_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pads_q <= '0;
    end else if (psel && penable && pwrite) begin
      pads_q[idx] <= pwdata[plb_pkg::PadW-1:0];
    end
  end

endmodule

// ----- hw/rtl/plb_front.sv -----
// Input register: label classification and padded edge candidates.
module plb_front #(
  parameter int FRAME_WIDTH  = 540,
  parameter int FRAME_HEIGHT = 960
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [plb_pkg::InTdataW-1:0]   s_axis_tdata,
  input  logic                           s_axis_tuser,
  input  logic                           s_axis_tlast,
  input  plb_pkg::pad_array_t            pads_i,
  input  logic                           fire_i,
  output logic                           valid_o,
  output plb_pkg::item_t                 item_o
);

  localparam int CW  = plb_pkg::CoordW;
  localparam int HW  = plb_pkg::HiW;
  localparam int TW  = $clog2(FRAME_WIDTH + 1);
  localparam int TH  = $clog2(FRAME_HEIGHT + 1);
  localparam int CWX = (TW > HW) ? TW : HW;
  localparam int CWY = (TH > HW) ? TH : HW;

  logic                        valid_q;
  plb_pkg::item_t              item_q;
  plb_pkg::item_t              item_d;
  logic [plb_pkg::LabelW-1:0]  label;
  logic [CW-1:0]               col;
  logic [CW-1:0]               row;
  logic                        pass1;
  logic [plb_pkg::PadW-1:0]    pad_l, pad_r, pad_t, pad_b;
  logic                        take;

  assign label = s_axis_tdata[plb_pkg::LabelW-1:0];
  assign col   = s_axis_tdata[plb_pkg::LabelW +: CW];
  assign row   = s_axis_tdata[plb_pkg::LabelW + CW +: CW];
  assign pass1 = s_axis_tuser;

  assign pad_l = pass1 ? pads_i[plb_pkg::REG_PAD_INNER_LEFT]   : pads_i[plb_pkg::REG_PAD_OUTER_LEFT];
  assign pad_r = pass1 ? pads_i[plb_pkg::REG_PAD_INNER_RIGHT]  : pads_i[plb_pkg::REG_PAD_OUTER_RIGHT];
  assign pad_t = pass1 ? pads_i[plb_pkg::REG_PAD_INNER_TOP]    : pads_i[plb_pkg::REG_PAD_OUTER_TOP];
  assign pad_b = pass1 ? pads_i[plb_pkg::REG_PAD_INNER_BOTTOM] : pads_i[plb_pkg::REG_PAD_OUTER_BOTTOM];

  always_comb begin
    item_d.outer_hit = !pass1 && (label >= plb_pkg::LabelOuterMin) && (label <= plb_pkg::LabelMax);
    item_d.inner_hit = pass1 && (label >= plb_pkg::LabelInnerMin) && (label <= plb_pkg::LabelMax);
    item_d.emit      = pass1 && s_axis_tlast;
    item_d.lo_x      = col - {1'b0, pad_l};
    item_d.lo_x_ok   = col >= {1'b0, pad_l};
    item_d.lo_y      = row - {1'b0, pad_t};
    item_d.lo_y_ok   = row >= {1'b0, pad_t};
    item_d.hi_x      = {1'b0, col} + {2'b00, pad_r};
    item_d.hi_y      = {1'b0, row} + {2'b00, pad_b};
    item_d.hi_x_ok   = CWX'(item_d.hi_x) < CWX'(FRAME_WIDTH);
    item_d.hi_y_ok   = CWY'(item_d.hi_y) < CWY'(FRAME_HEIGHT);
  end

  assign s_axis_tready = !valid_q || fire_i;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign valid_o       = valid_q;
  assign item_o        = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

endmodule

// ----- hw/rtl/plb_track.sv -----
// Edge trackers for both boxes and composition of the reported box.
module plb_track #(
  parameter int FRAME_WIDTH  = 540,
  parameter int FRAME_HEIGHT = 960
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  plb_pkg::item_t   item_i,
  output plb_pkg::box_t    box_o
);

  localparam int HW  = plb_pkg::HiW;
  localparam int OW  = plb_pkg::OutW;
  localparam int TW  = $clog2(FRAME_WIDTH + 1);
  localparam int TH  = $clog2(FRAME_HEIGHT + 1);
  localparam int CWX = (TW > HW) ? TW : HW;
  localparam int CWY = (TH > HW) ? TH : HW;

  logic [TW-1:0]  ol_q, or_q, il_q, ir_q, ol_n, or_n, il_n, ir_n, ol_d, or_d, il_d, ir_d;
  logic [TH-1:0]  ot_q, ob_q, it_q, ib_q, ot_n, ob_n, it_n, ib_n, ot_d, ob_d, it_d, ib_d;
  logic [CWX-1:0] lox, hix;
  logic [CWY-1:0] loy, hiy;
  logic           ox_empty, oy_empty, ix_empty, iy_empty;

  assign lox = CWX'(item_i.lo_x);
  assign hix = CWX'(item_i.hi_x);
  assign loy = CWY'(item_i.lo_y);
  assign hiy = CWY'(item_i.hi_y);

  always_comb begin
    ol_n = ol_q;
    or_n = or_q;
    ot_n = ot_q;
    ob_n = ob_q;
    il_n = il_q;
    ir_n = ir_q;
    it_n = it_q;
    ib_n = ib_q;
    if (item_i.outer_hit) begin
      if (item_i.lo_x_ok && lox < CWX'(ol_q)) ol_n = TW'(lox);
      if (item_i.hi_x_ok && hix > CWX'(or_q)) or_n = TW'(hix);
      if (item_i.lo_y_ok && loy < CWY'(ot_q)) ot_n = TH'(loy);
      if (item_i.hi_y_ok && hiy > CWY'(ob_q)) ob_n = TH'(hiy);
    end
    if (item_i.inner_hit) begin
      if (item_i.lo_x_ok && lox < CWX'(il_q) && lox > CWX'(ol_q)) il_n = TW'(lox);
      if (item_i.hi_x_ok && hix > CWX'(ir_q) && hix < CWX'(or_q)) ir_n = TW'(hix);
      if (item_i.lo_y_ok && loy < CWY'(it_q) && loy > CWY'(ot_q)) it_n = TH'(loy);
      if (item_i.hi_y_ok && hiy > CWY'(ib_q) && hiy < CWY'(ob_q)) ib_n = TH'(hiy);
    end
  end

  always_comb begin
    ox_empty = or_n <= ol_n;
    oy_empty = ob_n <= ot_n;
    ix_empty = ir_n <= il_n;
    iy_empty = ib_n <= it_n;
    box_o.outer_x_min = ox_empty ? '0 : OW'(ol_n);
    box_o.outer_x_max = ox_empty ? OW'(FRAME_WIDTH) : OW'(or_n);
    box_o.outer_y_min = oy_empty ? '0 : OW'(ot_n);
    box_o.outer_y_max = oy_empty ? OW'(FRAME_HEIGHT) : OW'(ob_n);
    box_o.inner_x_min = ix_empty ? box_o.outer_x_min : OW'(il_n);
    box_o.inner_x_max = ix_empty ? box_o.outer_x_max : OW'(ir_n);
    box_o.inner_y_min = iy_empty ? box_o.outer_y_min : OW'(it_n);
    box_o.inner_y_max = iy_empty ? box_o.outer_y_max : OW'(ib_n);
  end

  always_comb begin
    if (item_i.emit) begin
      ol_d = TW'(FRAME_WIDTH);
      or_d = '0;
      ot_d = TH'(FRAME_HEIGHT);
      ob_d = '0;
      il_d = TW'(FRAME_WIDTH);
      ir_d = '0;
      it_d = TH'(FRAME_HEIGHT);
      ib_d = '0;
    end else begin
      ol_d = ol_n;
      or_d = or_n;
      ot_d = ot_n;
      ob_d = ob_n;
      il_d = il_n;
      ir_d = ir_n;
      it_d = it_n;
      ib_d = ib_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ol_q <= TW'(FRAME_WIDTH);
      or_q <= '0;
      ot_q <= TH'(FRAME_HEIGHT);
      ob_q <= '0;
      il_q <= TW'(FRAME_WIDTH);
      ir_q <= '0;
      it_q <= TH'(FRAME_HEIGHT);
      ib_q <= '0;
    end else if (fire_i) begin
      ol_q <= ol_d;
      or_q <= or_d;
      ot_q <= ot_d;
      ob_q <= ob_d;
      il_q <= il_d;
      ir_q <= ir_d;
      it_q <= it_d;
      ib_q <= ib_d;
    end
  end

endmodule

// ----- hw/rtl/padded_label_bounding_box.sv -----
// Result: m_axis_tvalid rises once the item that ends pass 1 has moved from the input register
// into the result register, which it enters only when the result register is free.
// Throughput: one pixel per cycle; only an item that ends pass 1 waits in the input register
// for a free or draining result register, so s_axis_tready follows m_axis_tready combinationally.
// Reset: trackers return to the empty frame extents and all paddings clear to zero.
// Trackers also return to reset after every result.
module padded_label_bounding_box #(
  parameter int FRAME_WIDTH  = 540,
  parameter int FRAME_HEIGHT = 960
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [plb_pkg::AddrW-1:0]       paddr,
  input  logic [plb_pkg::DataW-1:0]       pwdata,
  output logic [plb_pkg::DataW-1:0]       prdata,
  output logic                            pready,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // label [7:0], col [17:8], row [27:18], zero fill [31:28]
  input  logic [plb_pkg::InTdataW-1:0]    s_axis_tdata,
  // pass_sel
  input  logic                            s_axis_tuser,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // outer_x_min, outer_x_max, outer_y_min, outer_y_max,
  // inner_x_min, inner_x_max, inner_y_min, inner_y_max; 10 bits each from bit 0
  output logic [plb_pkg::OutTdataW-1:0]   m_axis_tdata
);

  plb_pkg::pad_array_t pads;
  plb_pkg::item_t      s1_item;
  plb_pkg::box_t       box;
  logic                s1_valid;
  logic                s1_fire;
  logic                out_free;
  logic                m_valid_q;
  plb_pkg::box_t       m_box_q;

  plb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pads_o  (pads)
  );

  plb_front #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .pads_i        (pads),
    .fire_i        (s1_fire),
    .valid_o       (s1_valid),
    .item_o        (s1_item)
  );

  plb_track #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_track (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s1_fire),
    .item_i (s1_item),
    .box_o  (box)
  );

  assign out_free = !m_valid_q || m_axis_tready;
  assign s1_fire  = s1_valid && (!s1_item.emit || out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s1_fire && s1_item.emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_item.emit) begin
      m_box_q <= box;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_box_q.inner_y_max, m_box_q.inner_y_min,
                          m_box_q.inner_x_max, m_box_q.inner_x_min,
                          m_box_q.outer_y_max, m_box_q.outer_y_min,
                          m_box_q.outer_x_max, m_box_q.outer_x_min};

`ifndef NO_ASSERTIONS
  a_result_from_end_of_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s1_fire && s1_item.emit))
    else $error("result raised without a finished pass");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> s1_valid)
    else $error("input stalled with empty input register");

  a_inner_within_outer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (FRAME_WIDTH > 1023) || (FRAME_HEIGHT > 1023) ||
      ((m_box_q.outer_x_min <= m_box_q.inner_x_min) &&
       (m_box_q.inner_x_max <= m_box_q.outer_x_max) &&
       (m_box_q.outer_y_min <= m_box_q.inner_y_min) &&
       (m_box_q.inner_y_max <= m_box_q.outer_y_max)))
    else $error("inner box reported outside outer box");
`endif

endmodule
